### sv/assert_macros.svh
// Assertion macros for the RTL files, included by bca_core.
// ASSERT_CHK: the property must hold at every clock edge outside reset.
// ASSERT_NEVER: the expression must never be true outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CHK(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion check failed");
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("assertion never-condition hit");
`else
`define ASSERT_CHK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

### sv/bca_pkg.sv
package bca_pkg;

	// window geometry; WINDOW must be a power of two
	localparam int WINDOW      = 64;
	localparam int SAMPLE_BITS = 12;
	localparam int POS_W       = $clog2(WINDOW);
	localparam int SUM_W       = SAMPLE_BITS + POS_W;

	// configuration port
	localparam int DATA_W    = 32;
	localparam int REG_IDX_W = 1;
	localparam int PADDR_W   = REG_IDX_W + 2;

	localparam logic [REG_IDX_W-1:0] REG_MAX_SAMPLE = REG_IDX_W'(0);
	localparam logic [SAMPLE_BITS-1:0] MAX_SAMPLE_RST = {SAMPLE_BITS{1'b1}};

	// item state between the read and the write-back of the window memory
	typedef struct packed {
		logic [POS_W-1:0]       addr;
		logic [SAMPLE_BITS-1:0] stored;
		logic                   rej;
		logic                   filled;
		logic                   hit;
		logic                   fwd;
		logic [SAMPLE_BITS-1:0] fwd_data;
	} stage_t;

endpackage

### sv/boxcar_average_with_reject_top.sv
// Moving average over the last 64 ADC samples with out-of-range rejection.
// Takes one sample per clock cycle while the result channel is not stalled.
// Each sample gives one result, which passes the memory stage and then the
// output register before it is offered on the result channel.
// The window slots sit in a single-port-read, single-port-write memory: a
// sample reads its slot at the transfer, and in the memory stage the old value is
// swapped for the new one in a running sum and written back; a slot written
// back in the same cycle is forwarded. The window reads as all zero right
// after reset, with no clearing pass. A sample above max_sample (register 0,
// byte address 0, reset 4095) is stored as zero, flagged as rejected, and the
// next sample overwrites the same slot. window_filled rises once the write
// position has wrapped and stays set until reset.
module boxcar_average_with_reject_top import bca_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [PADDR_W-1:0]     paddr,
	input  logic [DATA_W-1:0]      pwdata,
	output logic [DATA_W-1:0]      prdata,
	output logic                   pready,
	input  logic                   sample_valid,
	output logic                   sample_stall,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic [SAMPLE_BITS-1:0] average,
	output logic                   window_filled,
	output logic                   rejected
);

	logic [SAMPLE_BITS-1:0] max_sample;

	// configuration registers
	bca_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.max_sample(max_sample)
	);

	// averaging datapath
	bca_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.max_sample   (max_sample),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.average      (average),
		.window_filled(window_filled),
		.rejected     (rejected)
	);

endmodule

### sv/bca_ram.sv
module bca_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, old data on a same-address write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/bca_cfg.sv
module bca_cfg import bca_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [PADDR_W-1:0]     paddr,
	input  logic [DATA_W-1:0]      pwdata,
	output logic [DATA_W-1:0]      prdata,
	output logic                   pready,
	output logic [SAMPLE_BITS-1:0] max_sample
);

	logic [REG_IDX_W-1:0]   reg_idx;
	logic                   wr_en;
	logic [SAMPLE_BITS-1:0] max_sample_q;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_sample_q <= MAX_SAMPLE_RST;
		end else if (wr_en && reg_idx == REG_MAX_SAMPLE) begin
			max_sample_q <= pwdata[SAMPLE_BITS-1:0];
		end
	end

	// register read
	always_comb begin
		case (reg_idx)
			REG_MAX_SAMPLE: prdata = DATA_W'(max_sample_q);
			default:        prdata = '0;
		endcase
	end

	assign max_sample = max_sample_q;

endmodule

### sv/bca_core.sv
`include "assert_macros.svh"

module bca_core import bca_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [SAMPLE_BITS-1:0] max_sample,
	input  logic                   sample_valid,
	output logic                   sample_stall,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic [SAMPLE_BITS-1:0] average,
	output logic                   window_filled,
	output logic                   rejected
);

	logic                   accept;
	logic                   advance;
	logic                   out_busy;
	logic                   rej;
	logic [SAMPLE_BITS-1:0] stored;
	logic                   wrap;

	logic [POS_W-1:0]       pos_q;
	logic                   filled_q;
	logic [WINDOW-1:0]      slot_vld_q;
	logic [SUM_W-1:0]       sum_q;

	logic                   valid_s1;
	stage_t                 st_s1;
	logic [SAMPLE_BITS-1:0] rdata;
	logic [SAMPLE_BITS-1:0] old_val;
	logic [SUM_W-1:0]       sum_nxt;

	logic                   result_valid_q;
	logic [SAMPLE_BITS-1:0] average_q;
	logic                   window_filled_q;
	logic                   rejected_q;

	// handshake: hold the item in the memory stage while the output is stalled
	assign out_busy     = result_valid_q && result_stall;
	assign advance      = valid_s1 && !out_busy;
	assign sample_stall = valid_s1 && out_busy;
	assign accept       = sample_valid && !sample_stall;

	// screen the sample and step the write position
	assign rej    = sample > max_sample;
	assign stored = rej ? '0 : sample;
	assign wrap   = !rej && (pos_q == POS_W'(WINDOW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			filled_q <= 1'b0;
		end else if (accept) begin
			if (!rej) begin
				pos_q <= pos_q + POS_W'(1);
			end
			if (wrap) begin
				filled_q <= 1'b1;
			end
		end
	end

	// window memory: read at accept, write back when the memory stage advances
	bca_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(WINDOW)
	) u_window (
		.clk  (clk),
		.we   (advance),
		.waddr(st_s1.addr),
		.wdata(st_s1.stored),
		.re   (accept),
		.raddr(pos_q),
		.rdata(rdata)
	);

	// memory stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// memory stage payload; forward the slot being written back this cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			st_s1.addr     <= pos_q;
			st_s1.stored   <= stored;
			st_s1.rej      <= rej;
			st_s1.filled   <= filled_q || wrap;
			st_s1.hit      <= slot_vld_q[pos_q];
			st_s1.fwd      <= advance && (st_s1.addr == pos_q);
			st_s1.fwd_data <= st_s1.stored;
		end
	end

	// slots never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_vld_q <= '0;
		end else if (advance) begin
			slot_vld_q[st_s1.addr] <= 1'b1;
		end
	end

	// update the running sum
	assign old_val = st_s1.fwd ? st_s1.fwd_data : (st_s1.hit ? rdata : '0);
	assign sum_nxt = sum_q - SUM_W'(old_val) + SUM_W'(st_s1.stored);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (advance) begin
			sum_q <= sum_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			average_q       <= sum_nxt[SUM_W-1:POS_W];
			window_filled_q <= st_s1.filled;
			rejected_q      <= st_s1.rej;
		end
	end

	assign result_valid  = result_valid_q;
	assign average       = average_q;
	assign window_filled = window_filled_q;
	assign rejected      = rejected_q;

	// back-to-back hits on one slot only happen after a rejected sample
	`ASSERT_CHK(a_fwd_after_reject, clk, arst_n,
		(accept && advance && st_s1.addr == pos_q) |-> st_s1.rej)
	// a rejected sample leaves the write position in place
	`ASSERT_CHK(a_reject_holds_pos, clk, arst_n,
		(accept && rej) |=> (pos_q == $past(pos_q)))
	// the filled flag is sticky
	`ASSERT_CHK(a_filled_sticky, clk, arst_n, filled_q |=> filled_q)
	// a stalled memory stage keeps its slot
	`ASSERT_CHK(a_s1_holds, clk, arst_n,
		(valid_s1 && !advance) |=> (valid_s1 && $stable(st_s1.addr)))

endmodule
